// ===== rtl/itoa_pkg.sv =====
`default_nettype none
package itoa_pkg;

  // Value and text sizes.
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned SIGNED_W   = 32;
  localparam int unsigned NUM_DIGITS = 20;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned CHAR_W     = 8;

  // Mode codes on func.
  localparam logic FUNC_UNSIGNED = 1'b0;
  localparam logic FUNC_SIGNED   = 1'b1;

  // Characters.
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  // Controls shared by every digit cell.
  typedef struct packed {
    logic clear;   // zero the digit
    logic dabble;  // add-3 adjust and shift one binary bit in
    logic unload;  // take the digit of the lower neighbor
  } itoa_cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/itoa_cell.sv =====
`default_nettype none
module itoa_cell (
  input  wire logic                          clk,
  input  wire itoa_pkg::itoa_cell_ctrl_t     ctrl,
  input  wire logic                          bit_in,
  input  wire logic [itoa_pkg::DIGIT_W-1:0]  digit_in,
  output logic                               carry_out,
  output logic      [itoa_pkg::DIGIT_W-1:0]  digit
);
  import itoa_pkg::*;

  logic [DIGIT_W-1:0] adjusted;

  // Add three to digits of five or more so the shift carries correctly.
  always_comb begin
    if (digit >= DIGIT_W'(5)) begin
      adjusted = digit + DIGIT_W'(3);
    end else begin
      adjusted = digit;
    end
  end

  // The adjusted top bit moves up into the next decimal place.
  assign carry_out = adjusted[DIGIT_W-1];

  // Digit register: clear, double-dabble shift, or shift digits upward.
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.dabble) begin
      digit <= {adjusted[DIGIT_W-2:0], bit_in};
    end else if (ctrl.unload) begin
      digit <= digit_in;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/integer_to_decimal_ascii_top.sv =====
`default_nettype none
// Integer to decimal ASCII text. Raise start with func and value while busy
// is low; the request is taken at that clock edge. A row of twenty BCD digit
// cells converts the value by shift-and-add-3, one binary bit per cycle for
// all 64 bits, then shifts the digits out from the top, skipping leading
// zeros. A negative signed value first gives '-'. After a request is taken,
// busy stays high through the sign step for a negative value, the conversion
// loop and the digit unload. The final character shows in the first cycle
// with busy low, so a new request can be taken at the end of that cycle. Each
// character appears on ascii_char for exactly one cycle with strobe high, and
// last_char marks the final one; the receiver cannot stall the block, so it
// must take every character in the cycle it is shown.
module integer_to_decimal_ascii_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          func,
  input  wire logic [itoa_pkg::VALUE_W-1:0]  value,
  output logic                               strobe,
  output logic      [itoa_pkg::CHAR_W-1:0]   ascii_char,
  output logic                               last_char
);
  import itoa_pkg::*;

  localparam int unsigned BIT_CNT_W = $clog2(VALUE_W);
  localparam int unsigned DIG_CNT_W = $clog2(NUM_DIGITS + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SIGN = 4'b0010,
    ST_CONV = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t                 state;
  state_t                 state_next;
  logic [VALUE_W-1:0]     shreg;
  logic [BIT_CNT_W-1:0]   bit_cnt;
  logic [DIG_CNT_W-1:0]   dig_cnt;
  logic                   started;
  logic                   accept;
  logic                   negative;
  logic [SIGNED_W-1:0]    low_mag;
  logic [VALUE_W-1:0]     mag;
  itoa_cell_ctrl_t        ctrl;
  logic [DIGIT_W-1:0]     digit [NUM_DIGITS];
  logic                   carry [NUM_DIGITS];
  logic [DIGIT_W-1:0]     top_digit;
  logic                   emit_now;
  logic                   last_now;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Magnitude of the request; signed mode reads the low word as two's complement.
  assign negative = (func == FUNC_SIGNED) && value[SIGNED_W-1];
  assign low_mag  = negative ? (SIGNED_W'(0) - value[SIGNED_W-1:0]) : value[SIGNED_W-1:0];
  assign mag      = (func == FUNC_SIGNED) ? {{(VALUE_W-SIGNED_W){1'b0}}, low_mag} : value;

  // Cell controls.
  assign ctrl.clear  = accept;
  assign ctrl.dabble = (state == ST_CONV);
  assign ctrl.unload = (state == ST_EMIT);

  // Row of digit cells; cell 0 is the least significant decimal place.
  for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
    if (g == 0) begin : g_first
      itoa_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .bit_in    (shreg[VALUE_W-1]),
        .digit_in  ('0),
        .carry_out (carry[g]),
        .digit     (digit[g])
      );
    end else begin : g_rest
      itoa_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .bit_in    (carry[g-1]),
        .digit_in  (digit[g-1]),
        .carry_out (carry[g]),
        .digit     (digit[g])
      );
    end
  end

  assign top_digit = digit[NUM_DIGITS-1];
  assign last_now  = (dig_cnt == DIG_CNT_W'(1));
  assign emit_now  = started || (top_digit != '0) || last_now;

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = negative ? ST_SIGN : ST_CONV;
        end
      end
      ST_SIGN: begin
        state_next = ST_CONV;
      end
      ST_CONV: begin
        if (bit_cnt == '0) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (last_now) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Binary shift register and loop counters.
  always_ff @(posedge clk) begin
    if (accept) begin
      shreg   <= mag;
      bit_cnt <= BIT_CNT_W'(VALUE_W - 1);
      dig_cnt <= DIG_CNT_W'(NUM_DIGITS);
      started <= 1'b0;
    end else if (state == ST_CONV) begin
      shreg   <= {shreg[VALUE_W-2:0], 1'b0};
      bit_cnt <= bit_cnt - BIT_CNT_W'(1);
    end else if (state == ST_EMIT) begin
      dig_cnt <= dig_cnt - DIG_CNT_W'(1);
      started <= emit_now;
    end
  end

  // Registered character output.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (state == ST_SIGN) || ((state == ST_EMIT) && emit_now);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SIGN) begin
      ascii_char <= CH_MINUS;
      last_char  <= 1'b0;
    end else begin
      ascii_char <= CH_ZERO | {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
      last_char  <= last_now;
    end
  end

  // The final character ends the request; nothing follows in the next cycle.
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && last_char |=> !strobe)
    else $error("character directly after the final character");

  // More characters are pending whenever a non-final one is shown.
  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_char |-> busy)
    else $error("non-final character while idle");

  // Only digits and the minus sign are produced.
  a_char_set: assert property (@(posedge clk) disable iff (rst)
    strobe |-> ((ascii_char >= CH_ZERO) && (ascii_char <= CH_NINE)) ||
               (ascii_char == CH_MINUS))
    else $error("character outside digits and minus sign");

  // An accepted request makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

endmodule
`default_nettype wire

// ===== tb/itoa_text_checker.sv =====
`default_nettype none
module itoa_text_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic                          busy,
  input  wire logic                          func,
  input  wire logic [itoa_pkg::VALUE_W-1:0]  value,
  input  wire logic                          strobe,
  input  wire logic [itoa_pkg::CHAR_W-1:0]   ascii_char,
  input  wire logic                          last_char,
  output int                                 mismatch_count,
  output int                                 pending_count,
  output int                                 chars_checked
);
  import itoa_pkg::*;

  // One character of the printed number and its end-of-number flag.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  text_char_t expected_chars[$];
  int         errors_seen = 0;
  int         chars_seen  = 0;

  // Appends the decimal text of one request to the expected characters.
  function automatic void predict_decimal_text(input logic mode,
                                               input logic [VALUE_W-1:0] num);
    logic [VALUE_W-1:0]  mag;
    logic [SIGNED_W-1:0] low;
    logic                negative;
    logic [CHAR_W-1:0]   digits[$];
    int                  i;
    negative = 1'b0;
    if (mode == FUNC_SIGNED) begin
      // Only the low word counts; its magnitude is taken as unsigned so the
      // most negative value survives the negation.
      low = num[SIGNED_W-1:0];
      if (low[SIGNED_W-1]) begin
        negative = 1'b1;
        low      = -low;
      end
      mag = VALUE_W'(low);
    end else begin
      mag = num;
    end
    // Digits come out least significant first; zero still gives one digit.
    do begin
      digits.push_front(CH_ZERO + CHAR_W'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (negative) begin
      expected_chars.push_back('{CH_MINUS, 1'b0});
    end
    for (i = 0; i < digits.size(); i++) begin
      expected_chars.push_back('{digits[i], i == digits.size() - 1});
    end
  endfunction

  // Characters are compared before a new request is queued, so a request
  // taken in the same cycle as a character cannot be mistaken for it.
  always @(posedge clk) begin
    text_char_t want;
    if (!rst) begin
      if (strobe) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: character %h (last %b) arrived with none expected",
                   $time, ascii_char, last_char);
          errors_seen++;
        end else begin
          want = expected_chars.pop_front();
          if (want.ch !== ascii_char) begin
            $display("%0t: ascii_char expected %h, actual %h",
                     $time, want.ch, ascii_char);
            errors_seen++;
          end
          if (want.last !== last_char) begin
            $display("%0t: last_char expected %b, actual %b",
                     $time, want.last, last_char);
            errors_seen++;
          end
          chars_seen++;
        end
      end
      if (start && !busy) begin
        predict_decimal_text(func, value);
      end
    end
    mismatch_count <= errors_seen;
    pending_count  <= expected_chars.size();
    chars_checked  <= chars_seen;
  end

endmodule
`default_nettype wire

// ===== tb/integer_to_decimal_ascii_top_test.sv =====
`default_nettype none
module integer_to_decimal_ascii_top_test;
  import itoa_pkg::*;

  localparam int RANDOM_NUMBERS = 245;
  localparam int STALL_LIMIT    = 1000;
  localparam int DRAIN_CYCLES   = 100;

  logic               clk;
  logic               rst   = 1'b1;
  logic               start = 1'b0;
  logic               func  = FUNC_UNSIGNED;
  logic [VALUE_W-1:0] value = '0;
  logic               busy;
  logic               strobe;
  logic [CHAR_W-1:0]  ascii_char;
  logic               last_char;

  int mismatch_count;
  int pending_count;
  int chars_checked;
  int numbers_sent = 0;
  int signed_sent  = 0;
  int stall_cycles = 0;
  int k;

  integer_to_decimal_ascii_top dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .value      (value),
    .strobe     (strobe),
    .ascii_char (ascii_char),
    .last_char  (last_char)
  );

  itoa_text_checker text_check (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .func           (func),
    .value          (value),
    .strobe         (strobe),
    .ascii_char     (ascii_char),
    .last_char      (last_char),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .chars_checked  (chars_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Ends the run when neither a request nor a character moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic logic [VALUE_W-1:0] power_of_ten(input int n);
    logic [VALUE_W-1:0] p;
    p = 1;
    repeat (n) p = p * 10;
    return p;
  endfunction

  // Random values spread over magnitudes, decade boundaries and small
  // negatives, with random upper bits for the signed mode.
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] r;
    logic [VALUE_W-1:0] p;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: return r;
      1: return r >> $urandom_range(0, VALUE_W - 1);
      2: begin
        p = power_of_ten($urandom_range(0, NUM_DIGITS - 1));
        case ($urandom_range(0, 2))
          0: return p;
          1: return p - 1;
          default: return p + $urandom_range(1, 9);
        endcase
      end
      3: return ~(r >> $urandom_range(0, VALUE_W - 1));
      default: return $urandom_range(0, 20);
    endcase
  endfunction

  // Holds the request until the block takes it; called just after an edge.
  task automatic issue_number(input logic mode, input logic [VALUE_W-1:0] num);
    start <= 1'b1;
    func  <= mode;
    value <= num;
    do @(posedge clk); while (busy);
    numbers_sent++;
    if (mode == FUNC_SIGNED) begin
      signed_sent++;
    end
  endtask

  // Sometimes drops start for a while, with junk on the request fields.
  task automatic maybe_idle();
    if ($urandom_range(0, 99) < 12) begin
      start <= 1'b0;
      func  <= 1'($urandom);
      value <= {$urandom, $urandom};
      repeat ($urandom_range(1, 100)) @(posedge clk);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests: zeros, extremes, decade edges and signed corners.
    issue_number(FUNC_UNSIGNED, 64'd0);
    issue_number(FUNC_SIGNED,   64'd0);
    issue_number(FUNC_SIGNED,   64'hFFFF_FFFF_0000_0000);
    issue_number(FUNC_UNSIGNED, 64'd1);
    issue_number(FUNC_UNSIGNED, 64'd9);
    issue_number(FUNC_UNSIGNED, 64'd10);
    issue_number(FUNC_UNSIGNED, 64'd99);
    issue_number(FUNC_UNSIGNED, 64'd100);
    issue_number(FUNC_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF);
    issue_number(FUNC_UNSIGNED, power_of_ten(19));
    issue_number(FUNC_UNSIGNED, power_of_ten(19) - 1);
    issue_number(FUNC_UNSIGNED, 64'h8000_0000_0000_0000);
    issue_number(FUNC_UNSIGNED, 64'h0000_0000_FFFF_FFFF);
    issue_number(FUNC_UNSIGNED, 64'hAAAA_AAAA_AAAA_AAAA);
    issue_number(FUNC_UNSIGNED, 64'h5555_5555_5555_5555);
    issue_number(FUNC_SIGNED,   64'h0000_0000_FFFF_FFFF);
    issue_number(FUNC_SIGNED,   64'h0000_0000_8000_0000);
    issue_number(FUNC_SIGNED,   64'hFFFF_FFFF_8000_0000);
    issue_number(FUNC_SIGNED,   64'h0000_0000_7FFF_FFFF);
    issue_number(FUNC_SIGNED,   64'hFFFF_FFFF_0000_007B);
    issue_number(FUNC_SIGNED,   64'hDEAD_BEEF_FFFF_FF85);
    issue_number(FUNC_SIGNED,   64'h0000_0000_FFFF_FFF6);
    issue_number(FUNC_SIGNED,   64'h0000_0000_0000_0009);
    issue_number(FUNC_SIGNED,   64'h5555_5555_AAAA_AAAA);

    // Random requests, with a long run in the middle that never idles.
    for (k = 0; k < RANDOM_NUMBERS; k++) begin
      issue_number(1'($urandom), pick_value());
      if (k < 80 || k >= 160) begin
        maybe_idle();
      end
    end
    start <= 1'b0;

    // Let every expected character arrive, then give the block time to
    // show anything extra.
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Printed %0d numbers (%0d signed, %0d unsigned) and checked %0d characters,",
             numbers_sent, signed_sent, numbers_sent - signed_sent, chars_checked);
    $display("covering zeros, both 64-bit extremes, decade edges and the most negative word.");
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== integer_to_decimal_ascii_top.f =====
rtl/itoa_pkg.sv
rtl/itoa_cell.sv
rtl/integer_to_decimal_ascii_top.sv
tb/itoa_text_checker.sv
tb/integer_to_decimal_ascii_top_test.sv
